/* src/pvcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvcd_pkg: shared types and constants of the prefix varint decoder
// Field widths, header and lead byte codes, status codes, register
// indexes and the control structs between the parser and the remainder unit.
// ----------------------------------------------------------------------------
package pvcd_pkg;

  localparam int VALUE_W = 24;
  localparam int MOD_W   = 32;
  localparam int POLY_W  = 8;
  localparam int COEFF_W = 16;
  localparam int CFG_IDX_W = 2;

  // Header layout.
  localparam logic [2:0] HDR_LEN     = 3'd5;
  localparam logic [7:0] HDR_VERSION = 8'h01;
  localparam logic [7:0] HDR_FORMAT  = 8'h03;

  // Lead byte classes.
  localparam logic [7:0] LEAD_ZERO   = 8'h00;
  localparam logic [7:0] LEAD_MASK1  = 8'hC0;
  localparam logic [7:0] LEAD_CODE1  = 8'h80;
  localparam logic [7:0] LEAD_MASK2  = 8'hE0;
  localparam logic [7:0] LEAD_CODE2  = 8'hC0;
  localparam logic [7:0] LEAD_MASK3  = 8'hF0;
  localparam logic [7:0] LEAD_CODE3  = 8'hE0;
  localparam logic [7:0] LEAD_CODE4  = 8'hF0;
  localparam logic [7:0] PAY_MASK1   = 8'h7F;
  localparam logic [7:0] PAY_MASK2   = 8'h3F;
  localparam logic [7:0] PAY_MASK3   = 8'h0F;

  // Register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 2'd2;
  localparam logic [MOD_W-1:0]   MODULUS_RST    = 32'd8380417;
  localparam logic [POLY_W-1:0]  POLY_COUNT_RST = 8'd1;
  localparam logic [COEFF_W-1:0] DEGREE_RST     = 16'd256;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FORMAT  = 3'd1,
    ST_DIMS    = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef struct packed {
    logic start;
    logic take;
  } rem_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

/* src/pvcd_rem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvcd_rem: serial remainder unit
// Restoring division of a 24-bit value by the 32-bit modulus, one quotient
// bit per cycle through a single compare and subtract.
// ----------------------------------------------------------------------------
module pvcd_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pvcd_pkg::rem_ctrl_t         ctrl,
  input  logic [pvcd_pkg::VALUE_W-1:0] dividend,
  input  logic [pvcd_pkg::MOD_W-1:0]   modulus,
  output pvcd_pkg::rem_stat_t         stat,
  output logic [pvcd_pkg::VALUE_W-1:0] remainder
);

  localparam int STEPS = pvcd_pkg::VALUE_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [pvcd_pkg::VALUE_W-1:0] dvd_r;
  logic [pvcd_pkg::VALUE_W-1:0] rem_r;
  logic [pvcd_pkg::VALUE_W-1:0] rem_nxt;
  logic [pvcd_pkg::VALUE_W:0]   shifted;
  logic [pvcd_pkg::MOD_W-1:0]   wide;
  logic [pvcd_pkg::MOD_W-1:0]   diff;

  // The partial remainder never exceeds the dividend prefix, so it fits in
  // 24 bits; a zero modulus always subtracts nothing and passes the value.
  always_comb begin
    shifted = {rem_r, dvd_r[pvcd_pkg::VALUE_W-1]};
    wide    = {{(pvcd_pkg::MOD_W - pvcd_pkg::VALUE_W - 1){1'b0}}, shifted};
    diff    = wide - modulus;
    rem_nxt = (wide >= modulus) ? diff[pvcd_pkg::VALUE_W-1:0]
                                : shifted[pvcd_pkg::VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctrl.start) begin
            dvd_r   <= dividend;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[pvcd_pkg::VALUE_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            state_r <= S_DONE;
          end
        end
        default: begin
          if (ctrl.take) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    stat.busy = (state_r != S_IDLE);
    stat.done = (state_r == S_DONE);
  end

  assign remainder = rem_r;

endmodule

/* src/prefix_varint_coeff_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint_coeff_decoder: header check and prefix-length code decoder
// Parses a byte stream into coefficients reduced modulo a configured modulus.
// ----------------------------------------------------------------------------
// Usage. Bytes arrive on the in_ channel, one request per byte, with
// in_end_of_stream set on the last one. Each request yields zero or one result
// request on the out_ channel: a coefficient with its polynomial and
// coefficient index, or a status report with out_final_res set.
// Timing. A byte that does not finish a code, or that gives an error or
// header report, leaves its report (if any) in the output register on the
// next cycle. A byte that completes a coefficient starts the serial
// remainder unit, which retires one quotient bit a cycle; the next byte is
// taken only once the unit's result has moved into the output register.
// Stalls. While out_stall holds a result in the output register, in_stall is
// raised as well; no result is ever dropped or repeated.
// Reset. rst_n, synchronous and active low, clears the parser and restores the
// register defaults (modulus 8380417, one polynomial, degree 256). Writes on
// the cfg_ port are meant for idle periods only.
// ----------------------------------------------------------------------------
module prefix_varint_coeff_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [pvcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pvcd_pkg::MOD_W-1:0]     cfg_wdata,
  // byte input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_stream,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pvcd_pkg::VALUE_W-1:0]   out_coefficient,
  output logic [pvcd_pkg::POLY_W-1:0]    out_poly_index,
  output logic [pvcd_pkg::COEFF_W-1:0]   out_coeff_index,
  output logic [2:0]                    out_status,
  output logic                          out_final_res
);

  // Configuration registers.
  logic [pvcd_pkg::MOD_W-1:0]   modulus_r;
  logic [pvcd_pkg::POLY_W-1:0]  poly_count_r;
  logic [pvcd_pkg::COEFF_W-1:0] degree_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= pvcd_pkg::MODULUS_RST;
      poly_count_r <= pvcd_pkg::POLY_COUNT_RST;
      degree_r     <= pvcd_pkg::DEGREE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pvcd_pkg::CFG_MODULUS:    modulus_r    <= cfg_wdata;
        pvcd_pkg::CFG_POLY_COUNT: poly_count_r <= cfg_wdata[pvcd_pkg::POLY_W-1:0];
        pvcd_pkg::CFG_DEGREE:     degree_r     <= cfg_wdata[pvcd_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Parser state.
  logic [2:0]                   header_pos_r, header_pos_nxt;
  logic [7:0]                   hdr_high_r, hdr_high_nxt;
  logic [1:0]                   bytes_pending_r, bytes_pending_nxt;
  logic [pvcd_pkg::VALUE_W-1:0] value_accum_r, value_accum_nxt;
  logic [pvcd_pkg::POLY_W-1:0]  cur_poly_r, cur_poly_nxt;
  logic [pvcd_pkg::COEFF_W-1:0] cur_coeff_r, cur_coeff_nxt;
  logic                         halted_r, halted_nxt;
  logic                         fmt_bad_r, fmt_bad_nxt;
  logic                         dims_bad_r, dims_bad_nxt;

  // Result control of the byte being taken.
  logic                         res_now;
  logic                         res_div;
  pvcd_pkg::status_t            res_status;
  logic                         res_final;
  logic [pvcd_pkg::VALUE_W-1:0] code_value;
  logic                         invalid_lead;

  logic [pvcd_pkg::COEFF_W:0]   next_coeff;
  logic [pvcd_pkg::POLY_W:0]    next_poly;
  logic                         wraps;
  logic                         last_coeff;

  logic                         in_accept;
  logic                         out_free;

  pvcd_pkg::rem_ctrl_t          rem_ctl;
  pvcd_pkg::rem_stat_t          rem_stat;
  logic [pvcd_pkg::VALUE_W-1:0] rem_value;

  // Output register.
  logic                         out_valid_r;
  logic [pvcd_pkg::VALUE_W-1:0] out_coef_r;
  logic [pvcd_pkg::POLY_W-1:0]  out_poly_r;
  logic [pvcd_pkg::COEFF_W-1:0] out_cidx_r;
  pvcd_pkg::status_t            out_status_r;
  logic                         out_final_r;

  // Indices of a coefficient waiting on the remainder unit.
  logic [pvcd_pkg::POLY_W-1:0]  pend_poly_r;
  logic [pvcd_pkg::COEFF_W-1:0] pend_cidx_r;
  logic                         pend_final_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = rem_stat.busy || !out_free;
  assign in_accept = in_valid && !in_stall;

  // A lowered degree can leave the index at or past degree, hence the
  // compare rather than an equality test.
  assign next_coeff = {1'b0, cur_coeff_r} + 1'b1;
  assign next_poly  = {1'b0, cur_poly_r} + 1'b1;
  assign wraps      = next_coeff >= {1'b0, degree_r};
  assign last_coeff = wraps && (next_poly >= {1'b0, poly_count_r});

  always_comb begin
    header_pos_nxt    = header_pos_r;
    hdr_high_nxt      = hdr_high_r;
    bytes_pending_nxt = bytes_pending_r;
    value_accum_nxt   = value_accum_r;
    cur_poly_nxt      = cur_poly_r;
    cur_coeff_nxt     = cur_coeff_r;
    halted_nxt        = halted_r;
    fmt_bad_nxt       = fmt_bad_r;
    dims_bad_nxt      = dims_bad_r;
    res_now           = 1'b0;
    res_div           = 1'b0;
    res_status        = pvcd_pkg::ST_OK;
    res_final         = 1'b0;
    code_value        = value_accum_r;
    invalid_lead      = 1'b0;

    if (halted_r) begin
      // Bytes after a final result are dropped until the stream ends.
    end else if (header_pos_r < pvcd_pkg::HDR_LEN) begin
      header_pos_nxt = header_pos_r + 1'b1;
      unique case (header_pos_r)
        3'd0: if (in_data_byte != pvcd_pkg::HDR_VERSION) fmt_bad_nxt = 1'b1;
        3'd1: if (in_data_byte != pvcd_pkg::HDR_FORMAT) fmt_bad_nxt = 1'b1;
        3'd2: if (in_data_byte != poly_count_r) dims_bad_nxt = 1'b1;
        3'd3: hdr_high_nxt = in_data_byte;
        default: if ({hdr_high_r, in_data_byte} != degree_r) dims_bad_nxt = 1'b1;
      endcase
      if (header_pos_r != pvcd_pkg::HDR_LEN - 1'b1) begin
        if (in_end_of_stream) begin
          res_now    = 1'b1;
          res_status = pvcd_pkg::ST_TRUNC;
          res_final  = 1'b1;
        end
      end else if (fmt_bad_nxt) begin
        res_now    = 1'b1;
        res_status = pvcd_pkg::ST_FORMAT;
        res_final  = 1'b1;
      end else if (dims_bad_nxt) begin
        res_now    = 1'b1;
        res_status = pvcd_pkg::ST_DIMS;
        res_final  = 1'b1;
      end else if (poly_count_r == '0 || degree_r == '0) begin
        res_now    = 1'b1;
        res_status = pvcd_pkg::ST_OK;
        res_final  = 1'b1;
      end else if (in_end_of_stream) begin
        res_now    = 1'b1;
        res_status = pvcd_pkg::ST_TRUNC;
        res_final  = 1'b1;
      end
    end else begin
      if (bytes_pending_r == 2'd0) begin
        if (in_data_byte == pvcd_pkg::LEAD_ZERO) begin
          code_value = '0;
        end else if ((in_data_byte & pvcd_pkg::LEAD_MASK1) == pvcd_pkg::LEAD_CODE1) begin
          code_value = {16'd0, in_data_byte & pvcd_pkg::PAY_MASK1};
        end else if ((in_data_byte & pvcd_pkg::LEAD_MASK2) == pvcd_pkg::LEAD_CODE2) begin
          code_value        = {16'd0, in_data_byte & pvcd_pkg::PAY_MASK2};
          bytes_pending_nxt = 2'd1;
        end else if ((in_data_byte & pvcd_pkg::LEAD_MASK3) == pvcd_pkg::LEAD_CODE3) begin
          code_value        = {16'd0, in_data_byte & pvcd_pkg::PAY_MASK3};
          bytes_pending_nxt = 2'd2;
        end else if (in_data_byte == pvcd_pkg::LEAD_CODE4) begin
          code_value        = '0;
          bytes_pending_nxt = 2'd3;
        end else begin
          invalid_lead = 1'b1;
        end
      end else begin
        code_value        = {value_accum_r[pvcd_pkg::VALUE_W-9:0], in_data_byte};
        bytes_pending_nxt = bytes_pending_r - 1'b1;
      end

      if (invalid_lead) begin
        res_now    = 1'b1;
        res_status = pvcd_pkg::ST_INVALID;
        res_final  = 1'b1;
      end else begin
        value_accum_nxt = code_value;
        if (bytes_pending_nxt != 2'd0) begin
          if (in_end_of_stream) begin
            res_now    = 1'b1;
            res_status = pvcd_pkg::ST_TRUNC;
            res_final  = 1'b1;
          end
        end else if (in_end_of_stream && !last_coeff) begin
          res_now    = 1'b1;
          res_status = pvcd_pkg::ST_TRUNC;
          res_final  = 1'b1;
        end else begin
          res_div   = 1'b1;
          res_final = last_coeff;
          if (!last_coeff) begin
            value_accum_nxt = '0;
            if (wraps) begin
              cur_coeff_nxt = '0;
              cur_poly_nxt  = next_poly[pvcd_pkg::POLY_W-1:0];
            end else begin
              cur_coeff_nxt = next_coeff[pvcd_pkg::COEFF_W-1:0];
            end
          end
        end
      end
    end

    if (res_final && !in_end_of_stream) begin
      halted_nxt = 1'b1;
    end

    // The end of the stream returns the parser to its reset state.
    if (in_end_of_stream) begin
      header_pos_nxt    = '0;
      hdr_high_nxt      = '0;
      bytes_pending_nxt = '0;
      value_accum_nxt   = '0;
      cur_poly_nxt      = '0;
      cur_coeff_nxt     = '0;
      halted_nxt        = 1'b0;
      fmt_bad_nxt       = 1'b0;
      dims_bad_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_pos_r    <= '0;
      hdr_high_r      <= '0;
      bytes_pending_r <= '0;
      value_accum_r   <= '0;
      cur_poly_r      <= '0;
      cur_coeff_r     <= '0;
      halted_r        <= 1'b0;
      fmt_bad_r       <= 1'b0;
      dims_bad_r      <= 1'b0;
    end else if (in_accept) begin
      header_pos_r    <= header_pos_nxt;
      hdr_high_r      <= hdr_high_nxt;
      bytes_pending_r <= bytes_pending_nxt;
      value_accum_r   <= value_accum_nxt;
      cur_poly_r      <= cur_poly_nxt;
      cur_coeff_r     <= cur_coeff_nxt;
      halted_r        <= halted_nxt;
      fmt_bad_r       <= fmt_bad_nxt;
      dims_bad_r      <= dims_bad_nxt;
    end
  end

  // The remainder unit does the modular reduction of the block. Its result is
  // taken as soon as the output register has room.
  always_comb begin
    rem_ctl.start = in_accept && res_div;
    rem_ctl.take  = rem_stat.done && out_free;
  end

  pvcd_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (rem_ctl),
    .dividend  (code_value),
    .modulus   (modulus_r),
    .stat      (rem_stat),
    .remainder (rem_value)
  );

  always_ff @(posedge clk) begin
    if (rem_ctl.start) begin
      pend_poly_r  <= cur_poly_r;
      pend_cidx_r  <= cur_coeff_r;
      pend_final_r <= res_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && res_now) begin
      out_valid_r  <= 1'b1;
      out_coef_r   <= '0;
      out_poly_r   <= cur_poly_r;
      out_cidx_r   <= cur_coeff_r;
      out_status_r <= res_status;
      out_final_r  <= res_final;
    end else if (rem_ctl.take) begin
      out_valid_r  <= 1'b1;
      out_coef_r   <= rem_value;
      out_poly_r   <= pend_poly_r;
      out_cidx_r   <= pend_cidx_r;
      out_status_r <= pvcd_pkg::ST_OK;
      out_final_r  <= pend_final_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_poly_index  = out_poly_r;
  assign out_coeff_index = out_cidx_r;
  assign out_status      = out_status_r;
  assign out_final_res   = out_final_r;

`ifndef SYNTHESIS
  // A started division must occupy the remainder unit on the next cycle.
  a_rem_runs: assert property (@(posedge clk) disable iff (!rst_n)
    rem_ctl.start |=> rem_stat.busy)
    else $error("remainder unit did not start");

  // Halting happens only once the header has been consumed.
  a_halt_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (header_pos_r == pvcd_pkg::HDR_LEN))
    else $error("halted inside the header");

  // Continuation bytes are only expected in the body.
  a_pending_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_pending_r != 2'd0) |-> (header_pos_r == pvcd_pkg::HDR_LEN))
    else $error("continuation pending inside the header");

  // Every error report closes the decode.
  a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != pvcd_pkg::ST_OK)) |-> out_final_r)
    else $error("error report without final mark");
`endif

endmodule

/* bench/prefix_varint_coeff_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint_coeff_decoder_tb: self-checking bench for the varint decoder
// Feeds byte streams with headers, prefix-length codes, broken and noisy
// sequences, tracks the decoder state in a scoreboard and compares every
// result request field by field under random idling on both channels.
// ----------------------------------------------------------------------------
import pvcd_pkg::*;

typedef struct packed {
  logic [VALUE_W-1:0] coefficient;
  logic [POLY_W-1:0]  poly_index;
  logic [COEFF_W-1:0] coeff_index;
  status_t            status;
  logic               final_res;
} coeff_result_t;

class coeff_scoreboard;
  logic [MOD_W-1:0]   modulus;
  logic [POLY_W-1:0]  poly_count;
  logic [COEFF_W-1:0] degree;

  logic [2:0]         hdr_pos;
  logic [7:0]         hdr_high;
  logic [1:0]         bytes_due;
  logic [VALUE_W-1:0] accum;
  logic [POLY_W-1:0]  cur_poly;
  logic [COEFF_W-1:0] cur_coeff;
  bit                 halted;
  bit                 format_bad;
  bit                 dims_bad;

  coeff_result_t      due_results[$];
  int unsigned        mismatches;

  function new();
    mismatches = 0;
    modulus    = MODULUS_RST;
    poly_count = POLY_COUNT_RST;
    degree     = DEGREE_RST;
    clear_stream();
  endfunction

  function void clear_stream();
    hdr_pos    = '0;
    hdr_high   = '0;
    bytes_due  = '0;
    accum      = '0;
    cur_poly   = '0;
    cur_coeff  = '0;
    halted     = 1'b0;
    format_bad = 1'b0;
    dims_bad   = 1'b0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MOD_W-1:0] val);
    case (idx)
      CFG_MODULUS:    modulus    = val;
      CFG_POLY_COUNT: poly_count = val[POLY_W-1:0];
      CFG_DEGREE:     degree     = val[COEFF_W-1:0];
      default: ;
    endcase
  endfunction

  function void push_expected(logic [VALUE_W-1:0] coef, status_t st, logic fin);
    coeff_result_t r;
    r.coefficient = coef;
    r.poly_index  = cur_poly;
    r.coeff_index = cur_coeff;
    r.status      = st;
    r.final_res   = fin;
    due_results = {due_results, r};
  endfunction

  // A final report ends the stream: the decoder halts, or starts over at
  // the end-of-stream byte.
  function void close_stream(logic [VALUE_W-1:0] coef, status_t st, logic eos);
    push_expected(coef, st, 1'b1);
    if (eos) clear_stream();
    else halted = 1'b1;
  endfunction

  // Notes one accepted byte. Returns 0 when the decoder merely skips it.
  function bit note_byte(logic [7:0] b, logic eos);
    int unsigned  nxt;
    bit           wraps;
    bit           last;
    logic [31:0]  val;
    if (halted) begin
      if (eos) clear_stream();
      return 1'b0;
    end
    if (hdr_pos < HDR_LEN) begin
      case (hdr_pos)
        3'd0: if (b != HDR_VERSION) format_bad = 1'b1;
        3'd1: if (b != HDR_FORMAT) format_bad = 1'b1;
        3'd2: if (b != poly_count) dims_bad = 1'b1;
        3'd3: hdr_high = b;
        default: if ({hdr_high, b} != degree) dims_bad = 1'b1;
      endcase
      hdr_pos = hdr_pos + 3'd1;
      if (hdr_pos < HDR_LEN) begin
        if (eos) close_stream('0, ST_TRUNC, 1'b1);
      end else if (format_bad) begin
        close_stream('0, ST_FORMAT, eos);
      end else if (dims_bad) begin
        close_stream('0, ST_DIMS, eos);
      end else if (poly_count == 0 || degree == 0) begin
        close_stream('0, ST_OK, eos);
      end else if (eos) begin
        close_stream('0, ST_TRUNC, 1'b1);
      end
      return 1'b1;
    end
    if (bytes_due == 0) begin
      if (b == LEAD_ZERO) begin
        accum = '0;
      end else if ((b & LEAD_MASK1) == LEAD_CODE1) begin
        accum = 24'(b & PAY_MASK1);
      end else if ((b & LEAD_MASK2) == LEAD_CODE2) begin
        accum = 24'(b & PAY_MASK2);
        bytes_due = 2'd1;
      end else if ((b & LEAD_MASK3) == LEAD_CODE3) begin
        accum = 24'(b & PAY_MASK3);
        bytes_due = 2'd2;
      end else if (b == LEAD_CODE4) begin
        accum = '0;
        bytes_due = 2'd3;
      end else begin
        close_stream('0, ST_INVALID, eos);
        return 1'b1;
      end
    end else begin
      accum = {accum[VALUE_W-9:0], b};
      bytes_due = bytes_due - 2'd1;
    end
    if (bytes_due != 0) begin
      if (eos) close_stream('0, ST_TRUNC, 1'b1);
      return 1'b1;
    end
    nxt   = 32'(cur_coeff) + 32'd1;
    wraps = nxt >= 32'(degree);
    last  = wraps && (32'(cur_poly) + 32'd1 >= 32'(poly_count));
    if (eos && !last) begin
      close_stream('0, ST_TRUNC, 1'b1);
      return 1'b1;
    end
    val = 32'(accum);
    if (modulus != 0) val = val % modulus;
    if (last) begin
      close_stream(val[VALUE_W-1:0], ST_OK, eos);
      return 1'b1;
    end
    push_expected(val[VALUE_W-1:0], ST_OK, 1'b0);
    if (wraps) begin
      cur_coeff = '0;
      cur_poly  = cur_poly + 8'd1;
    end else begin
      cur_coeff = nxt[COEFF_W-1:0];
    end
    accum = '0;
    return 1'b1;
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_coeff(coeff_result_t got);
    coeff_result_t want;
    if (due_results.size() == 0) begin
      $error("result with nothing expected: coefficient %0d status %0d",
             got.coefficient, got.status);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    compare_field("coefficient", 32'(want.coefficient), 32'(got.coefficient));
    compare_field("poly_index", 32'(want.poly_index), 32'(got.poly_index));
    compare_field("coeff_index", 32'(want.coeff_index), 32'(got.coeff_index));
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("final_res", 32'(want.final_res), 32'(got.final_res));
  endfunction
endclass

module prefix_varint_coeff_decoder_tb;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 6;
  // A completed code keeps the block busy until its remainder is taken; give it
  // some margin before touching the registers or ending the run.
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BYTES   = 1650;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MOD_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte = '0;
  logic                 in_end_of_stream = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VALUE_W-1:0]   out_coefficient;
  logic [POLY_W-1:0]    out_poly_index;
  logic [COEFF_W-1:0]   out_coeff_index;
  logic [2:0]           out_status;
  logic                 out_final_res;

  coeff_scoreboard      sb;
  logic [7:0]           stream_q[$];
  int unsigned          decoded_bytes = 0;
  int unsigned          quiet_cycles = 0;
  // While calm is set neither side idles; hold_off_req asks the receiver for
  // one long stall.
  bit                   calm = 1'b0;
  bit                   hold_off_req = 1'b0;

  prefix_varint_coeff_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coefficient  (out_coefficient),
    .out_poly_index   (out_poly_index),
    .out_coeff_index  (out_coeff_index),
    .out_status       (out_status),
    .out_final_res    (out_final_res)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Both channels are sampled at the rising edge, before the block's own
  // updates land, so the scoreboard sees exactly what the block saw. The
  // same block runs the watchdog: it counts edges at which neither channel
  // moves a request.
  always @(posedge clk) begin : channel_monitor
    coeff_result_t got;
    bit            moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      void'(sb.note_byte(in_data_byte, in_end_of_stream));
      decoded_bytes++;
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      got.coefficient = out_coefficient;
      got.poly_index  = out_poly_index;
      got.coeff_index = out_coeff_index;
      got.status      = status_t'(out_status);
      got.final_res   = out_final_res;
      sb.check_coeff(got);
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stalls about a third of the time, except in calm stretches.
  // On request it holds off for a long stretch so that the result register
  // fills and the block pushes back on its input.
  initial begin : result_receiver
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 32);
    end
  end

  // Offers one byte and returns at the edge where it is taken. A random
  // gap may come first; valid is then lowered and raised at different edges.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering, waits for every expected result, then lets the block
  // finish whatever byte it may still be chewing on.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MOD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_registers(input logic [MOD_W-1:0] m, input logic [POLY_W-1:0] pc,
                                input logic [COEFF_W-1:0] dg);
    cfg_write(CFG_MODULUS, m);
    cfg_write(CFG_POLY_COUNT, pc);
    cfg_write(CFG_DEGREE, dg);
  endtask

  function automatic void add_byte(logic [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  function automatic void push_header(logic [7:0] ver, logic [7:0] fmt,
                                      logic [7:0] pc, logic [15:0] dg);
    add_byte(ver);
    add_byte(fmt);
    add_byte(pc);
    add_byte(dg[15:8]);
    add_byte(dg[7:0]);
  endfunction

  // One prefix-length code of random length and content. A few leads are
  // deliberately invalid.
  function automatic void push_code();
    logic [23:0] v;
    int          r;
    v = $urandom_range(7) == 0 ? 24'hFFFFFF : 24'($urandom);
    r = $urandom_range(99);
    if (r < 3) begin
      add_byte($urandom_range(1) ? 8'($urandom_range(8'h01, 8'h7F))
                                 : 8'($urandom_range(8'hF1, 8'hFF)));
    end else if (r < 20) begin
      add_byte(LEAD_ZERO);
    end else if (r < 40) begin
      add_byte(LEAD_CODE1 | {2'b00, v[5:0]});
    end else if (r < 60) begin
      add_byte(LEAD_CODE2 | {3'b000, v[4:0]});
      add_byte(v[7:0]);
    end else if (r < 80) begin
      add_byte(LEAD_CODE3 | {4'b0000, v[3:0]});
      add_byte(v[15:8]);
      add_byte(v[7:0]);
    end else begin
      add_byte(LEAD_CODE4);
      add_byte(v[23:16]);
      add_byte(v[15:8]);
      add_byte(v[7:0]);
    end
  endfunction

  // Sends the buffered stream with the end mark on its last byte. A nonzero
  // split pauses there and lowers a degree above one before the rest goes out.
  task automatic send_stream(input int split);
    int i;
    for (i = 0; i < stream_q.size(); i++) begin
      if (split > 0 && i == split && sb.degree > 16'd1) begin
        settle();
        cfg_write(CFG_DEGREE, $urandom_range(1, sb.degree - 1));
      end
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
  endtask

  task automatic random_settings();
    logic [MOD_W-1:0]   m;
    logic [POLY_W-1:0]  pc;
    logic [COEFF_W-1:0] dg;
    case ($urandom_range(9))
      0:       m = 32'd1;
      1:       m = 32'hFFFF_FFFF;
      2:       m = 32'd0;
      3:       m = MODULUS_RST;
      4, 5:    m = $urandom_range(2, 300);
      6:       m = $urandom;
      default: m = $urandom_range(2, 24'hFFFFFF);
    endcase
    case ($urandom_range(19))
      0:       pc = 8'd0;
      1:       pc = 8'd255;
      2:       pc = 8'($urandom);
      default: pc = 8'($urandom_range(1, 3));
    endcase
    case ($urandom_range(19))
      0:       dg = 16'd0;
      1:       dg = 16'd65535;
      2:       dg = 16'($urandom);
      default: dg = 16'($urandom_range(1, 6));
    endcase
    load_registers(m, pc, dg);
  endtask

  // Most streams are well formed with random codes; the rest carry a bad
  // version or format, wrong dimensions, a short header, or plain noise.
  // Streams of the first three kinds may be cut short or carry trailing bytes.
  task automatic random_stream();
    int         r;
    int         n_codes;
    int         split;
    int         k;
    logic [7:0] bad;
    stream_q.delete();
    split = 0;
    r = $urandom_range(99);
    bad = 8'($urandom_range(2, 255));
    if (r < 72) begin
      push_header(HDR_VERSION, HDR_FORMAT, sb.poly_count, sb.degree);
    end else if (r < 80) begin
      if ($urandom_range(1)) push_header(bad ^ HDR_VERSION, HDR_FORMAT,
                                         sb.poly_count, sb.degree);
      else push_header(HDR_VERSION, bad ^ HDR_FORMAT, sb.poly_count, sb.degree);
    end else if (r < 88) begin
      if ($urandom_range(1)) push_header(HDR_VERSION, HDR_FORMAT, sb.poly_count ^ bad,
                                         sb.degree);
      else push_header(HDR_VERSION, HDR_FORMAT, sb.poly_count,
                       sb.degree ^ (16'd1 << $urandom_range(15)));
    end else if (r < 94) begin
      push_header(HDR_VERSION, HDR_FORMAT, sb.poly_count, sb.degree);
      k = $urandom_range(1, 4);
      while (stream_q.size() > k) void'(stream_q.pop_back());
    end else begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
    end
    if (r < 88) begin
      n_codes = int'(sb.poly_count) * int'(sb.degree);
      if (n_codes > 14) n_codes = $urandom_range(1, 14);
      if ($urandom_range(9) == 0) n_codes++;
      repeat (n_codes) push_code();
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      if (stream_q.size() > 1 && $urandom_range(9) == 0) begin
        k = $urandom_range(1, stream_q.size() - 1);
        while (stream_q.size() > k) void'(stream_q.pop_back());
      end
      if (r < 72 && stream_q.size() > 7 && $urandom_range(15) == 0)
        split = $urandom_range(6, stream_q.size() - 1);
    end
    send_stream(split);
  endtask

  initial begin : stimulus
    int          phase;
    int unsigned target;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A stream that ends on its first byte: the short header report.
    stream_q = {HDR_VERSION};
    send_stream(0);
    settle();

    // Every code length with all payload bits set, under the widest
    // modulus; the last code is also the last coefficient.
    load_registers(32'hFFFF_FFFF, 8'd1, 16'd5);
    stream_q.delete();
    push_header(HDR_VERSION, HDR_FORMAT, 8'd1, 16'd5);
    add_byte(LEAD_ZERO);
    add_byte(LEAD_CODE1 | PAY_MASK2);
    add_byte(LEAD_CODE2 | 8'h1F);
    add_byte(8'hFF);
    add_byte(LEAD_CODE3 | PAY_MASK3);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(LEAD_CODE4);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    send_stream(0);

    // Bad format and bad dimensions at once, ending on the fifth byte:
    // the format report must win.
    stream_q = {8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF};
    send_stream(0);

    target = decoded_bytes + RANDOM_BYTES;
    phase = 0;
    while (decoded_bytes < target) begin
      settle();
      calm = (phase >= 6 && phase < 12);
      if (phase == 3) begin
        // Long receiver hold-off against a long stream of codes.
        load_registers(MODULUS_RST, 8'd1, 16'd40);
        stream_q.delete();
        push_header(HDR_VERSION, HDR_FORMAT, 8'd1, 16'd40);
        repeat (40) push_code();
        hold_off_req = 1'b1;
        send_stream(0);
      end else begin
        random_settings();
        repeat (4) random_stream();
      end
      phase++;
    end

    settle();
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
